>>> design/hs24_pkg.sv
// hs24_pkg: types, constants and round functions shared by the halfsiphash pipeline
// used by hs24_cell and the top level halfsiphash_2_4_fixed_8byte
// no dependencies
package hs24_pkg;

   localparam int COMPRESS_ROUNDS = 2;
   localparam int FINAL_ROUNDS    = 4;
   localparam int ABSORB_STAGES   = 3 * COMPRESS_ROUNDS;
   localparam int NUM_STAGES      = ABSORB_STAGES + 2 * FINAL_ROUNDS;

   localparam logic [31:0] IV_V2        = 32'h6c796765;
   localparam logic [31:0] IV_V3        = 32'h74656462;
   localparam logic [31:0] TWEAK_OUT64  = 32'h000000ee;
   localparam logic [31:0] TWEAK_SECOND = 32'h000000dd;
   localparam logic [31:0] LEN_WORD     = 32'(8) << 24;

   localparam logic [1:0] CSR_HASH_KEY   = 2'd0;
   localparam logic [1:0] CSR_FOLD_TO_32 = 2'd1;

   typedef enum logic [1:0] {
      WORD_LOW,
      WORD_HIGH,
      WORD_LEN
   } hs_word_type;

   // per-cell operation, fixed by the cell's place in the row
   typedef struct packed {
      logic        pre_v3;
      logic        pre_v2;
      logic        pre_v1;
      logic        post_v0;
      logic        take_lo;
      hs_word_type word_sel;
   } hs_op_type;

   typedef struct packed {
      logic [3:0][31:0] v;
      logic [63:0]      msg;
      logic [31:0]      lo;
   } hs_data_type;

   typedef struct packed {
      logic        valid;
      hs_data_type data;
   } hs_stage_type;

   function automatic logic [31:0] rotl32(input logic [31:0] x, input int r);
      return (x << r) | (x >> (32 - r));
   endfunction

   function automatic logic [3:0][31:0] sip_round(input logic [3:0][31:0] v_i);
      logic [3:0][31:0] v;
      v = v_i;
      v[0] = v[0] + v[1]; v[1] = rotl32(v[1], 5);  v[1] = v[1] ^ v[0]; v[0] = rotl32(v[0], 16);
      v[2] = v[2] + v[3]; v[3] = rotl32(v[3], 8);  v[3] = v[3] ^ v[2];
      v[0] = v[0] + v[3]; v[3] = rotl32(v[3], 7);  v[3] = v[3] ^ v[0];
      v[2] = v[2] + v[1]; v[1] = rotl32(v[1], 13); v[1] = v[1] ^ v[2]; v[2] = rotl32(v[2], 16);
      return v;
   endfunction

   function automatic hs_op_type stage_op(input int s);
      hs_op_type op;
      op          = '0;
      op.word_sel = WORD_LOW;
      if (s < ABSORB_STAGES) begin
         op.pre_v3  = ((s % COMPRESS_ROUNDS) == 0);
         op.post_v0 = ((s % COMPRESS_ROUNDS) == (COMPRESS_ROUNDS - 1));
         case (s / COMPRESS_ROUNDS)
            0:       op.word_sel = WORD_LOW;
            1:       op.word_sel = WORD_HIGH;
            default: op.word_sel = WORD_LEN;
         endcase
      end
      op.pre_v2  = (s == ABSORB_STAGES);
      op.pre_v1  = (s == ABSORB_STAGES + FINAL_ROUNDS);
      op.take_lo = (s == ABSORB_STAGES + FINAL_ROUNDS - 1);
      return op;
   endfunction

endpackage

>>> design/hs24_cell.sv
// hs24_cell: one sipround cell of the hash pipeline, with its optional xor steps
// depends on hs24_pkg for the stage types and the round function
// holds one word in flight and stalls only when its downstream neighbour is full
module hs24_cell import hs24_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  hs_op_type    op,
   input  hs_stage_type up,
   output logic         up_ready,
   output hs_stage_type down,
   input  logic         down_ready
);

   logic        valid_ff, valid_in;
   hs_data_type data_ff, data_in;
   logic [31:0] m;
   logic [3:0][31:0] v;

   always_comb begin
      unique case (op.word_sel)
         WORD_LOW:  m = up.data.msg[31:0];
         WORD_HIGH: m = up.data.msg[63:32];
         WORD_LEN:  m = LEN_WORD;
         default:   m = LEN_WORD;
      endcase
      v = up.data.v;
      if (op.pre_v3) v[3] = v[3] ^ m;
      if (op.pre_v2) v[2] = v[2] ^ TWEAK_OUT64;
      if (op.pre_v1) v[1] = v[1] ^ TWEAK_SECOND;
      v = sip_round(v);
      if (op.post_v0) v[0] = v[0] ^ m;
      data_in   = up.data;
      data_in.v = v;
      // first output half is taken at the end of the first finalisation pass
      if (op.take_lo) data_in.lo = v[1] ^ v[3];
   end

   assign up_ready = !valid_ff || down_ready;
   assign valid_in = up_ready ? up.valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up.valid) begin
         data_ff <= data_in;
      end
   end

   assign down.valid = valid_ff;
   assign down.data  = data_ff;

endmodule

>>> design/halfsiphash_2_4_fixed_8byte.sv
// halfsiphash_2_4_fixed_8byte: keyed halfsiphash-2-4, 64-bit output or a 32-bit fold of it, over one 8-byte word
// depends on hs24_pkg and hs24_cell
//
//  channel  direction  handshake              payload
//  req      in         req_tvalid/req_tready  req_tdata[63:0]  message
//  rsp      out        rsp_tvalid/rsp_tready  rsp_tdata[63:0]  hash_value
//  csr      in         csr_valid/csr_ready    csr_index[1:0], csr_wdata[63:0]
//
// a row of 14 round cells, one sipround each; a word enters every cycle unless rsp back-pressure
// stalls the row, and its hash, registered in each cell in turn, is on rsp from the last cell's register
// each cell stalls only when the cell after it is full, so bubbles close up under stalls
// synchronous reset empties the row and clears the key and the fold flag
// csr writes are always taken; out of range indexes are ignored
module halfsiphash_2_4_fixed_8byte import hs24_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [63:0] message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [63:0] hash_value
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   logic [63:0]  hash_key_ff;
   logic         fold_ff;
   hs_stage_type stage [NUM_STAGES+1];
   logic         stage_ready [NUM_STAGES+1];
   logic [31:0]  k0, k1, hi;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_key_ff <= '0;
         fold_ff     <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_HASH_KEY)   hash_key_ff <= csr_wdata;
         if (csr_index == CSR_FOLD_TO_32) fold_ff     <= csr_wdata[0];
      end
   end

   assign k0 = hash_key_ff[31:0];
   assign k1 = hash_key_ff[63:32];

   always_comb begin
      stage[0].valid     = req_tvalid;
      stage[0].data.v[0] = k0;
      stage[0].data.v[1] = k1 ^ TWEAK_OUT64;
      stage[0].data.v[2] = IV_V2 ^ k0;
      stage[0].data.v[3] = IV_V3 ^ k1;
      stage[0].data.msg  = req_tdata;
      stage[0].data.lo   = '0;
   end

   assign req_tready = stage_ready[0];

   for (genvar g = 0; g < NUM_STAGES; g++) begin : g_cell
      hs24_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .op         (stage_op(g)),
         .up         (stage[g]),
         .up_ready   (stage_ready[g]),
         .down       (stage[g+1]),
         .down_ready (stage_ready[g+1])
      );
   end

   assign stage_ready[NUM_STAGES] = rsp_tready;
   assign rsp_tvalid = stage[NUM_STAGES].valid;
   assign hi = stage[NUM_STAGES].data.v[1] ^ stage[NUM_STAGES].data.v[3];
   assign rsp_tdata = fold_ff ? {32'h0, stage[NUM_STAGES].data.lo ^ hi}
                              : {hi, stage[NUM_STAGES].data.lo};

   a_fold_upper_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && fold_ff) |-> (rsp_tdata[63:32] == 32'h0))
      else $error("fold mode result has non-zero upper half");

   a_reset_empties: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> !rsp_tvalid)
      else $error("result valid straight after reset");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> stage[1].valid)
      else $error("accepted word did not reach the first cell");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("input stalled while the output side is free");

endmodule
